FILE: hdl/psbl_pkg.sv
// ----------------------------------------------------------------------------
// psbl_pkg
// Shared types, constants and keyword match functions for the stream body
// locator.
// ----------------------------------------------------------------------------
package psbl_pkg;

  // Default parameter values
  localparam int OFFSET_BITS_DEF = 32;
  localparam int MAX_RECORDS_DEF = 4096;

  // Register and field widths
  localparam int CFG_W    = 13;
  localparam int INDEX_W  = 12;
  localparam int FIELD_W  = 32;
  localparam logic [CFG_W-1:0] MAX_STREAMS_RST = 13'd4096;

  // Keyword lengths and characters
  localparam logic [2:0] START_LEN = 3'd6;
  localparam logic [3:0] END_LEN   = 4'd9;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  // Scan phase
  typedef enum logic [1:0] {
    PH_SEEK_START = 2'd0,
    PH_SKIP_START = 2'd1,
    PH_SEEK_END   = 2'd2,
    PH_SKIP_END   = 2'd3
  } phase_t;

  // One stream record
  typedef struct packed {
    logic [FIELD_W-1:0] body_size;
    logic [FIELD_W-1:0] body_offset;
    logic [INDEX_W-1:0] stream_index;
  } record_t;

  // "stream"
  function automatic logic [7:0] start_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h61;
      3'd5:    c = 8'h6d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "endstream"
  function automatic logic [7:0] end_char(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:    c = 8'h65;
      4'd1:    c = 8'h6e;
      4'd2:    c = 8'h64;
      4'd3:    c = 8'h73;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h72;
      4'd6:    c = 8'h65;
      4'd7:    c = 8'h61;
      4'd8:    c = 8'h6d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Match step for "stream": no self overlap, fallback always to zero
  function automatic logic [2:0] start_step(input logic [2:0] k, input logic [7:0] b);
    logic [2:0] kk;
    logic [2:0] r;
    kk = (k >= START_LEN) ? 3'd0 : k;
    if (b == start_char(kk)) begin
      r = kk + 3'd1;
    end else if (b == start_char(3'd0)) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Match step for "endstream": after "endstre" a mismatch falls back to "e"
  function automatic logic [3:0] end_step(input logic [3:0] k, input logic [7:0] b);
    logic [3:0] kk;
    logic [3:0] r;
    kk = (k >= END_LEN) ? 4'd0 : k;
    if (b == end_char(kk)) begin
      r = kk + 4'd1;
    end else if (kk == 4'd7 && b == end_char(4'd1)) begin
      r = 4'd2;
    end else if (b == end_char(4'd0)) begin
      r = 4'd1;
    end else begin
      r = 4'd0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/pdf_stream_body_locator.sv
// ----------------------------------------------------------------------------
// pdf_stream_body_locator
// Finds stream bodies between "stream" and "endstream" in a byte stream.
// ----------------------------------------------------------------------------
// Feed the document one byte per request on the in_ channel, tlast on the
// final byte of each buffer; scan state clears after that byte. Each
// "endstream" that closes a body yields one record on the out_ channel with
// the stream index, body offset and body size. Throughput is one byte per
// clock while the output is not stalled: the byte sits in an input register,
// the match logic is combinational and a record lands in the output register.
// A stalled output holds the input register, which then holds in_tready low.
// max_streams must be written over the cfg_ channel while the block is idle;
// the block does not enforce this, and cfg_ready is always high.
module pdf_stream_body_locator
  import psbl_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input bytes
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // last_byte
  // stream records
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [79:0]      out_tdata,  // [11:0] stream_index, [43:12] body_offset,
                                       // [75:44] body_size, [79:76] zero
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data    // max_streams
);

  localparam int REC_BITS = $bits(record_t);

  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic             out_v_r, out_v_nxt;
  record_t          out_rec_r;
  logic [CFG_W-1:0] max_streams_r;
  logic             proceed;
  logic             emit;
  record_t          record;

  // Handshake control
  assign proceed   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proceed;
  assign cfg_ready = 1'b1;

  always_comb begin
    out_v_nxt = out_v_r;
    if (proceed && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_streams_r <= MAX_STREAMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_streams_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Scanner
  psbl_scanner #(
    .OFFSET_BITS(OFFSET_BITS),
    .MAX_RECORDS(MAX_RECORDS)
  ) u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proceed),
    .data_byte  (in_byte_r),
    .last_byte  (in_last_r),
    .max_streams(max_streams_r),
    .emit       (emit),
    .record     (record)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emit) begin
      out_rec_r <= record;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(80 - REC_BITS)'(0), out_rec_r};

endmodule

FILE: hdl/psbl_scanner.sv
// ----------------------------------------------------------------------------
// psbl_scanner
// Scan state and per-byte keyword logic; one byte is consumed per step.
// ----------------------------------------------------------------------------
module psbl_scanner
  import psbl_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [CFG_W-1:0] max_streams,
  output logic             emit,
  output record_t          record
);

  localparam int REC_W = $clog2(MAX_RECORDS + 1);
  localparam int LIM_W = (REC_W > CFG_W) ? REC_W : CFG_W;
  localparam logic [LIM_W-1:0] MAX_REC = LIM_W'(MAX_RECORDS);
  localparam int WIDE_W = 64;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             smp_r, smp_nxt;
  logic [3:0]             emp_r, emp_nxt;
  logic [OFFSET_BITS-1:0] body_start_r, body_start_nxt;
  logic [OFFSET_BITS-1:0] size_base_r, size_base_nxt;
  logic [LIM_W-1:0]       rec_r, rec_nxt;

  logic [LIM_W-1:0]       limit;
  logic                   active;
  logic [2:0]             smp_step;
  logic [3:0]             emp_step;
  logic                   start_hit;
  logic                   end_hit;
  logic [OFFSET_BITS-1:0] size_calc;
  logic [WIDE_W-1:0]      ofs_wide;
  logic [WIDE_W-1:0]      size_wide;

  // Effective record limit
  always_comb begin
    limit  = (LIM_W'(max_streams) < MAX_REC) ? LIM_W'(max_streams) : MAX_REC;
    active = rec_r < limit;
  end

  // Keyword matchers
  always_comb begin
    smp_step  = start_step(smp_r, data_byte);
    emp_step  = end_step(emp_r, data_byte);
    start_hit = (smp_step == START_LEN);
    end_hit   = (emp_step == END_LEN);
  end

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      unique case (phase_r)
        PH_SEEK_START: if (start_hit) phase_nxt = PH_SKIP_START;
        PH_SKIP_START: phase_nxt = PH_SEEK_END;
        PH_SEEK_END:   if (end_hit) phase_nxt = PH_SKIP_END;
        PH_SKIP_END:   phase_nxt = PH_SEEK_START;
        default:       phase_nxt = PH_SEEK_START;
      endcase
    end
    if (last_byte) phase_nxt = PH_SEEK_START;
  end

  // Datapath and record output
  always_comb begin
    pos_nxt        = pos_r + OFFSET_BITS'(1);
    smp_nxt        = smp_r;
    emp_nxt        = emp_r;
    body_start_nxt = body_start_r;
    size_base_nxt  = size_base_r;
    rec_nxt        = rec_r;
    emit           = 1'b0;
    size_calc      = pos_r - OFFSET_BITS'(8) - size_base_r;
    if (active) begin
      unique case (phase_r)
        PH_SEEK_START: begin
          smp_nxt = start_hit ? 3'd0 : smp_step;
        end
        PH_SKIP_START: begin
          size_base_nxt  = pos_r + OFFSET_BITS'(1);
          body_start_nxt = pos_r + OFFSET_BITS'(1);
          emp_nxt        = 4'd0;
        end
        PH_SEEK_END: begin
          // line feed right after the skipped byte moves the body on by one
          if (pos_r == size_base_r && data_byte == CHAR_LF) begin
            body_start_nxt = size_base_r + OFFSET_BITS'(1);
          end
          emp_nxt = end_hit ? 4'd0 : emp_step;
          if (end_hit) begin
            emit    = 1'b1;
            rec_nxt = rec_r + LIM_W'(1);
          end
        end
        PH_SKIP_END: begin
          smp_nxt = 3'd0;
        end
        default: begin
          smp_nxt = 3'd0;
        end
      endcase
    end
    ofs_wide                 = WIDE_W'(body_start_nxt);
    size_wide                = WIDE_W'(size_calc);
    record.stream_index      = rec_r[INDEX_W-1:0];
    record.body_offset       = ofs_wide[FIELD_W-1:0];
    record.body_size         = size_wide[FIELD_W-1:0];
    // end of buffer clears the scan
    if (last_byte) begin
      pos_nxt        = '0;
      smp_nxt        = 3'd0;
      emp_nxt        = 4'd0;
      body_start_nxt = '0;
      size_base_nxt  = '0;
      rec_nxt        = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= PH_SEEK_START;
      smp_r        <= 3'd0;
      emp_r        <= 4'd0;
      body_start_r <= '0;
      size_base_r  <= '0;
      rec_r        <= '0;
    end else if (step) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      smp_r        <= smp_nxt;
      emp_r        <= emp_nxt;
      body_start_r <= body_start_nxt;
      size_base_r  <= size_base_nxt;
      rec_r        <= rec_nxt;
    end
  end

endmodule

FILE: sim/pdf_stream_body_locator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdf_stream_body_locator_tb
// Self-checking testbench for the stream body locator. Bytes are pushed in on
// the in_ channel with random gaps. A scanner model in the testbench predicts
// each stream record, and every record on the out_ channel is compared field
// by field with the oldest prediction. The run covers directed keyword cases,
// limit changes between and within buffers, long output stalls that back up
// the input, and a long random part made mostly of well-formed streams.
// ----------------------------------------------------------------------------
module pdf_stream_body_locator_tb;
  import psbl_pkg::*;

  localparam int        DRAIN_CYCLES = 8;           // idle wait after the last record is out
  localparam logic [47:0] KW_STREAM  = "stream";
  localparam logic [71:0] KW_END     = "endstream";
  localparam string     BYTE_POOL    = "streamnd\n";

  // DUT signals
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;   // [7:0] data_byte
  logic             in_tlast   = 1'b0;    // last_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [79:0]      out_tdata;            // [11:0] stream_index, [43:12] body_offset,
                                          // [75:44] body_size, [79:76] zero
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data   = '0;      // max_streams

  // Scanner model state
  logic [CFG_W-1:0] max_streams_q = MAX_STREAMS_RST;
  logic [31:0]      cur_pos;
  phase_t           phase_q;
  logic [3:0]       start_prog;
  logic [3:0]       end_prog;
  logic [31:0]      body_off;
  logic [31:0]      size_origin;
  logic [CFG_W-1:0] found_cnt;

  // Bookkeeping
  record_t          pending_records[$];
  logic [7:0]       frame_bytes[$];
  record_t          got_rec;
  record_t          exp_rec;
  int               error_count     = 0;
  int               bytes_sent      = 0;
  int               records_checked = 0;
  int               rx_hold         = 0;
  int               rx_wait         = 0;
  bit               calm            = 1'b0;

  pdf_stream_body_locator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timeout: %0d records still expected", pending_records.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------
  // Scanner model
  // ------------------------------------------------------------------

  // One matcher step with fallback; only a mismatch after "endstre" falls back to 1
  function automatic logic [3:0] kw_advance(input bit is_end, input logic [3:0] k_in,
                                            input logic [7:0] b);
    logic [3:0] k;
    logic [3:0] len;
    logic [7:0] c;
    len = is_end ? 4'd9 : 4'd6;
    k = (k_in >= len) ? 4'd0 : k_in;
    for (int i = 0; i < 10; i++) begin
      c = is_end ? KW_END[8*(8-k) +: 8] : KW_STREAM[8*(5-k) +: 8];
      if (b == c) return k + 4'd1;
      if (k == 4'd0) return 4'd0;
      k = (is_end && k == 4'd7) ? 4'd1 : 4'd0;
    end
    return 4'd0;
  endfunction

  task automatic clear_scan();
    cur_pos     = '0;
    phase_q     = PH_SEEK_START;
    start_prog  = '0;
    end_prog    = '0;
    body_off    = '0;
    size_origin = '0;
    found_cnt   = '0;
  endtask

  // Advance the model by one accepted byte, queue a record if one closes
  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [31:0]      pos;
    logic [CFG_W-1:0] lim;
    logic [3:0]       k;
    record_t          rec;
    pos = cur_pos;
    lim = (max_streams_q < MAX_RECORDS_DEF) ? max_streams_q : CFG_W'(MAX_RECORDS_DEF);
    if (found_cnt < lim) begin
      case (phase_q)
        PH_SEEK_START: begin
          k = kw_advance(1'b0, start_prog, b);
          if (k == 4'd6) begin
            k = '0;
            phase_q = PH_SKIP_START;
          end
          start_prog = k;
        end
        PH_SKIP_START: begin
          size_origin = pos + 32'd1;
          body_off    = size_origin;
          end_prog    = '0;
          phase_q     = PH_SEEK_END;
        end
        PH_SEEK_END: begin
          // a line feed right after the skipped byte moves the body on
          if (pos == size_origin && b == CHAR_LF) body_off = size_origin + 32'd1;
          k = kw_advance(1'b1, end_prog, b);
          if (k == 4'd9) begin
            rec.stream_index = found_cnt[INDEX_W-1:0];
            rec.body_offset  = body_off;
            rec.body_size    = pos - 32'd8 - size_origin;
            pending_records.push_back(rec);
            found_cnt = found_cnt + 1'b1;
            k = '0;
            phase_q = PH_SKIP_END;
          end
          end_prog = k;
        end
        default: begin
          start_prog = '0;
          phase_q    = PH_SEEK_START;
        end
      endcase
    end
    cur_pos = pos + 32'd1;
    if (last) clear_scan();
  endtask

  // ------------------------------------------------------------------
  // Drivers and checker
  // ------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one byte request and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], close && (i == frame_bytes.size() - 1));
    frame_bytes.delete();
  endtask

  // Stop sending until every expected record is out and the pipe is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_streams(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_streams_q = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Receiver: random stalls, plus a hold-off counted down here
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait    <= rx_wait - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm) begin
        case ($urandom_range(0, 19))
          0, 1, 2: rx_wait <= $urandom_range(1, 3);
          3:       rx_wait <= $urandom_range(15, 50);
          default: rx_wait <= 0;
        endcase
      end
    end
  end

  // Record checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with none expected, body_offset", out_tdata[43:12], '0);
      end else begin
        exp_rec = pending_records.pop_front();
        got_rec = record_t'(out_tdata[75:0]);
        if (got_rec.stream_index != exp_rec.stream_index)
          report_mismatch("stream_index", 32'(got_rec.stream_index),
                          32'(exp_rec.stream_index));
        if (got_rec.body_offset != exp_rec.body_offset)
          report_mismatch("body_offset", got_rec.body_offset, exp_rec.body_offset);
        if (got_rec.body_size != exp_rec.body_size)
          report_mismatch("body_size", got_rec.body_size, exp_rec.body_size);
        if (out_tdata[79:76] != '0)
          report_mismatch("pad bits", 32'(out_tdata[79:76]), '0);
        records_checked++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  task automatic push_text(input string s, input int count);
    for (int i = 0; i < count && i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  // Mostly keyword letters and line feeds, otherwise any byte
  function automatic logic [7:0] any_byte();
    if ($urandom_range(0, 1) == 0) return BYTE_POOL[$urandom_range(0, BYTE_POOL.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_stream_body(input int body_max, input bit terminate);
    push_text("stream", 6);
    frame_bytes.push_back(any_byte());
    if ($urandom_range(0, 1) == 0) frame_bytes.push_back(CHAR_LF);
    repeat ($urandom_range(0, body_max)) frame_bytes.push_back(any_byte());
    if (terminate) begin
      push_text("endstream", 9);
      frame_bytes.push_back(any_byte());
    end
  endtask

  // A buffer of well-formed streams, noise and broken keywords
  task automatic build_random_frame();
    int r;
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_stream_body(10, $urandom_range(0, 9) != 0);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(any_byte());
      end else begin
        if ($urandom_range(0, 1) == 0) push_text("stream", $urandom_range(1, 5));
        else push_text("endstream", $urandom_range(1, 8));
        frame_bytes.push_back(any_byte());
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Keyword at offset 0, line feed body start, overlapped end keyword,
  // byte extremes, then a buffer that ends inside a body
  task automatic test_directed();
    push_text("stream", 6);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(CHAR_LF);
    push_text("endstrendstream", 15);
    frame_bytes.push_back(8'h00);
    send_frame(1'b1);
    push_text("stream", 6);
    push_text("x\nab", 4);
    send_frame(1'b1);
    wait_idle();
  endtask

  // Limit lowered while a buffer is still open
  task automatic test_limit_lowered();
    write_max_streams(13'h1FFF);
    push_stream_body(4, 1'b1);
    push_stream_body(4, 1'b1);
    send_frame(1'b0);
    wait_idle();
    write_max_streams(13'd1);
    push_stream_body(4, 1'b1);
    send_frame(1'b1);
    wait_idle();
  endtask

  task automatic test_random_phase(input logic [CFG_W-1:0] limit, input int n_items,
                                   input bit quiet);
    int target;
    wait_idle();
    write_max_streams(limit);
    calm   = quiet;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      build_random_frame();
      send_frame($urandom_range(0, 7) != 0);
    end
    calm = 1'b0;
  endtask

  // Receiver holds off while streams close back to back
  task automatic test_backpressure();
    wait_idle();
    write_max_streams(MAX_STREAMS_RST);
    rx_hold = 300;
    calm    = 1'b1;
    repeat (8) begin
      push_text("stream", 6);
      push_text("xab", 3);
      push_text("endstream", 9);
      frame_bytes.push_back(8'h20);
    end
    send_frame(1'b1);
    calm = 1'b0;
    wait_idle();
  endtask

  // Sender pauses inside a buffer until all records are out
  task automatic test_drain_pause();
    push_stream_body(6, 1'b1);
    push_text("stream", 6);
    frame_bytes.push_back(8'h41);
    send_frame(1'b0);
    wait_idle();
    push_text("body", 4);
    push_text("endstream", 9);
    frame_bytes.push_back(8'h0D);
    send_frame(1'b1);
  endtask

  // Main sequence
  initial begin
    clear_scan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_limit_lowered();
    test_random_phase(MAX_STREAMS_RST, 220, 1'b0);
    test_random_phase(13'd1, 150, 1'b0);
    test_random_phase(13'd0, 110, 1'b0);
    test_random_phase(13'h1FFF, 220, 1'b1);
    test_random_phase(13'd2, 150, 1'b0);
    test_random_phase(CFG_W'($urandom_range(0, 8191)), 190, 1'b0);
    test_random_phase(13'd3, 120, 1'b0);
    test_backpressure();
    test_drain_pause();
    wait_idle();

    $display("Summary: %0d bytes sent, %0d stream records checked, %0d mismatches",
             bytes_sent, records_checked, error_count);
    $display("Limits 0, 1, 2, 3, 4096, 8191 and one random value; stalls and pauses included");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
